// ===== design/rbngc_pkg.sv =====
`timescale 1ns / 1ps
package rbngc_pkg;
   localparam int MAX_POINTS = 1024;
   localparam int MAX_GROUPS = 8;
   localparam int MAX_BINS   = 4;
   localparam int IDX_W   = 10;
   localparam int CNT_W   = 11;
   localparam int POS_W   = 20;
   localparam int GRP_W   = 3;
   localparam int BIN_W   = 2;
   localparam int TAL_W   = 10;
   localparam int RAD_W   = 43;
   localparam int DIF_W   = 21;
   localparam int SQ_W    = 42;
   localparam int NTAL    = MAX_GROUPS * MAX_BINS;
   localparam int TIDX_W  = 5;
   localparam logic [TAL_W-1:0] TAL_MAX = '1;

   localparam logic [1:0] MODE_LOAD  = 2'd0;
   localparam logic [1:0] MODE_QUERY = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   localparam logic [2:0] CSR_NUM_GROUPS = 3'd0;
   localparam logic [2:0] CSR_NUM_BINS   = 3'd1;
   localparam logic [2:0] CSR_RADIUS_0   = 3'd2;
   localparam logic [2:0] CSR_RADIUS_3   = 3'd5;

   typedef struct packed {
      logic             load;
      logic             clear;
      logic             fetch_q;
      logic             latch_q;
      logic             scan_rd;
      logic [IDX_W-1:0] scan_idx;
      logic             tally_clr;
      logic             out_load;
      logic             out_err;
      logic [GRP_W-1:0] out_grp;
      logic [BIN_W-1:0] out_bin;
      logic             out_last;
   } cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic             pipe_busy;
   } stat_type;
endpackage

// ===== design/radius_binned_neighbor_group_counter.sv =====
`timescale 1ns / 1ps
// Load and clear transactions are handled in the idle state, which keeps req_ready high.
// A query fetches its point, then scans one point per cycle through the single store read
// port, drains, then gives num_groups * num_bins results, one per cycle when unstalled.
// A bad query index (not below the stored count) gives its single error result from the error state.
// Synchronous active-high reset empties the store count and restores register defaults;
// point store contents are not cleared.
module radius_binned_neighbor_group_counter
   import rbngc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_mode,
   input  logic [POS_W-1:0] req_pos_x,
   input  logic [POS_W-1:0] req_pos_y,
   input  logic [GRP_W-1:0] req_group_label,
   input  logic [IDX_W-1:0] req_query_index,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [GRP_W-1:0] rsp_out_group,
   output logic [BIN_W-1:0] rsp_out_bin,
   output logic [TAL_W-1:0] rsp_neighbor_count,
   output logic             rsp_last,
   output logic             rsp_error,
   input  logic             csr_write,
   input  logic [2:0]       csr_index,
   input  logic [RAD_W-1:0] csr_data
);
   logic [3:0]       ngroups_ff;
   logic [2:0]       nbins_ff;
   logic [RAD_W-1:0] rad_ff [MAX_BINS];
   logic [GRP_W:0]   ng;
   logic [BIN_W:0]   nb;
   cmd_type          cmd;
   stat_type         stat;

   // register file; hold written values until reset
   always_ff @(posedge clock) begin
      if (reset) begin
         ngroups_ff <= 4'(MAX_GROUPS);
         nbins_ff   <= 3'(MAX_BINS);
         for (int i = 0; i < MAX_BINS; i++) rad_ff[i] <= '0;
      end else if (csr_write) begin
         if (csr_index == CSR_NUM_GROUPS) ngroups_ff <= csr_data[3:0];
         if (csr_index == CSR_NUM_BINS)   nbins_ff   <= csr_data[2:0];
         for (int i = 0; i < MAX_BINS; i++) begin
            if (csr_index == CSR_RADIUS_0 + 3'(i)) rad_ff[i] <= csr_data;
         end
      end
   end

   // saturate counts into their legal ranges
   assign ng = (ngroups_ff == 4'd0) ? (GRP_W+1)'(1) :
               (ngroups_ff > 4'(MAX_GROUPS)) ? (GRP_W+1)'(MAX_GROUPS) : ngroups_ff;
   assign nb = (nbins_ff == 3'd0) ? (BIN_W+1)'(1) :
               (nbins_ff > 3'(MAX_BINS)) ? (BIN_W+1)'(MAX_BINS) : nbins_ff;

   rbngc_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_mode, .req_group_label,
      .req_query_index, .ng, .nb, .rsp_valid, .rsp_ready, .stat, .cmd
   );

   rbngc_datapath u_dp (
      .clock, .reset, .cmd, .stat,
      .in_x(req_pos_x), .in_y(req_pos_y), .in_grp(req_group_label),
      .in_q(req_query_index), .ng, .nb, .rad(rad_ff), .rsp_ready,
      .rsp_valid, .rsp_out_group, .rsp_out_bin, .rsp_neighbor_count,
      .rsp_last, .rsp_error
   );

`ifndef SYNTHESIS
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last && !rsp_ready) |=> rsp_valid) else $error("last dropped");
   a_cfg_range: assert property (@(posedge clock) disable iff (reset)
      ng != '0 && nb != '0) else $error("count not saturated");
   a_err_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error) |-> rsp_last) else $error("error result malformed");
`endif
endmodule

// ===== design/rbngc_datapath.sv =====
`timescale 1ns / 1ps
module rbngc_datapath
   import rbngc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output stat_type               stat,
   input  logic [POS_W-1:0]       in_x,
   input  logic [POS_W-1:0]       in_y,
   input  logic [GRP_W-1:0]       in_grp,
   input  logic [IDX_W-1:0]       in_q,
   input  logic [GRP_W:0]         ng,
   input  logic [BIN_W:0]         nb,
   input  logic [RAD_W-1:0]       rad [MAX_BINS],
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic [GRP_W-1:0]       rsp_out_group,
   output logic [BIN_W-1:0]       rsp_out_bin,
   output logic [TAL_W-1:0]       rsp_neighbor_count,
   output logic                   rsp_last,
   output logic                   rsp_error
);
   logic [POS_W-1:0] mem_x [MAX_POINTS];
   logic [POS_W-1:0] mem_y [MAX_POINTS];
   logic [GRP_W-1:0] mem_g [MAX_POINTS];
   logic [CNT_W-1:0] count_ff;
   logic [POS_W-1:0] rd_x_ff, rd_y_ff, qx_ff, qy_ff;
   logic [GRP_W-1:0] rd_g_ff;
   logic [IDX_W-1:0] q_ff;
   logic             s1_v_ff, s2_v_ff;
   logic [IDX_W-1:0] s1_idx_ff;
   logic [SQ_W-1:0]  sqx_ff, sqy_ff;
   logic             s2_skip_ff;
   logic [GRP_W-1:0] s2_g_ff;
   logic [TAL_W-1:0] tally_ff [NTAL];
   logic             ov_ff;
   logic [GRP_W-1:0] og_ff;
   logic [BIN_W-1:0] ob_ff;
   logic [TAL_W-1:0] oc_ff;
   logic             ol_ff, oe_ff;

   logic signed [DIF_W-1:0] dx, dy;
   logic [DIF_W-1:0] ax, ay;
   logic [RAD_W-1:0] d2;
   logic             hit;
   logic [BIN_W-1:0] hbin;
   logic [TIDX_W-1:0] tsel;
   logic [BIN_W:0]   nb_m1;
   logic [RAD_W-1:0] rad_last;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mem_x[count_ff[IDX_W-1:0]] <= in_x;
         mem_y[count_ff[IDX_W-1:0]] <= in_y;
         mem_g[count_ff[IDX_W-1:0]] <= in_grp;
      end
      if (cmd.fetch_q || cmd.scan_rd) begin
         rd_x_ff <= mem_x[cmd.fetch_q ? in_q : cmd.scan_idx];
         rd_y_ff <= mem_y[cmd.fetch_q ? in_q : cmd.scan_idx];
         rd_g_ff <= mem_g[cmd.fetch_q ? in_q : cmd.scan_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.clear) begin
         count_ff <= '0;
      end else if (cmd.load) begin
         count_ff <= count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fetch_q) q_ff <= in_q;
      if (cmd.latch_q) begin
         qx_ff <= rd_x_ff;
         qy_ff <= rd_y_ff;
      end
   end

   // stage 1: read data valid; stage 2: squares; stage 3: bin and tally
   assign dx = DIF_W'(signed'(qx_ff)) - DIF_W'(signed'(rd_x_ff));
   assign dy = DIF_W'(signed'(qy_ff)) - DIF_W'(signed'(rd_y_ff));
   assign ax = dx[DIF_W-1] ? DIF_W'(-dx) : DIF_W'(dx);
   assign ay = dy[DIF_W-1] ? DIF_W'(-dy) : DIF_W'(dy);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= cmd.scan_rd;
         s2_v_ff <= s1_v_ff;
      end
      s1_idx_ff  <= cmd.scan_idx;
      sqx_ff     <= ax * ax;
      sqy_ff     <= ay * ay;
      s2_skip_ff <= (s1_idx_ff == q_ff) || ({1'b0, rd_g_ff} >= ng);
      s2_g_ff    <= rd_g_ff;
   end

   assign d2 = RAD_W'(sqx_ff) + RAD_W'(sqy_ff);

   assign nb_m1    = nb - (BIN_W+1)'(1);
   assign rad_last = rad[nb_m1[BIN_W-1:0]];

   always_comb begin
      hit  = 1'b0;
      hbin = '0;
      for (int b = MAX_BINS - 1; b >= 0; b--) begin
         if (BIN_W'(b) < nb[BIN_W-1:0] || nb == (BIN_W+1)'(MAX_BINS)) begin
            if (rad[b] >= d2) begin
               hit  = 1'b1;
               hbin = BIN_W'(b);
            end
         end
      end
      // drop points beyond the last bin in use, even where an earlier radius covers them
      hit  = hit && (rad_last >= d2);
      tsel = TIDX_W'({s2_g_ff, hbin});
   end

   always_ff @(posedge clock) begin
      if (cmd.tally_clr) begin
         for (int i = 0; i < NTAL; i++) tally_ff[i] <= '0;
      end else if (s2_v_ff && !s2_skip_ff && hit && tally_ff[tsel] != TAL_MAX) begin
         tally_ff[tsel] <= tally_ff[tsel] + TAL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (cmd.out_load) begin
         ov_ff <= 1'b1;
      end else if (rsp_ready) begin
         ov_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         og_ff <= cmd.out_grp;
         ob_ff <= cmd.out_bin;
         oc_ff <= cmd.out_err ? '0 : tally_ff[TIDX_W'({cmd.out_grp, cmd.out_bin})];
         ol_ff <= cmd.out_last;
         oe_ff <= cmd.out_err;
      end
   end

   assign stat.count     = count_ff;
   assign stat.pipe_busy = s1_v_ff || s2_v_ff;
   assign rsp_valid          = ov_ff;
   assign rsp_out_group      = og_ff;
   assign rsp_out_bin        = ob_ff;
   assign rsp_neighbor_count = oc_ff;
   assign rsp_last           = ol_ff;
   assign rsp_error          = oe_ff;

`ifndef SYNTHESIS
   a_load_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> count_ff < CNT_W'(MAX_POINTS)) else $error("load past capacity");
   a_stage_flow: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_rd |=> s1_v_ff) else $error("scan stage lost");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!ov_ff || rsp_ready)) else $error("result overwritten");
`endif
endmodule

// ===== design/rbngc_ctrl.sv =====
`timescale 1ns / 1ps
module rbngc_ctrl
   import rbngc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_mode,
   input  logic [GRP_W-1:0] req_group_label,
   input  logic [IDX_W-1:0] req_query_index,
   input  logic [GRP_W:0]   ng,
   input  logic [BIN_W:0]   nb,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  stat_type         stat,
   output cmd_type          cmd
);
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_QRD   = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;
   localparam logic [2:0] ST_ERR   = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [GRP_W-1:0] g_ff, g_in;
   logic [BIN_W-1:0] b_ff, b_in;
   logic             acc, slot_free, g_end, b_end;

   assign req_ready = (state_ff == ST_IDLE);
   assign acc       = req_valid && req_ready;
   assign slot_free = !rsp_valid || rsp_ready;
   assign g_end     = ({1'b0, g_ff} == ng - (GRP_W+1)'(1));
   assign b_end     = ({1'b0, b_ff} == nb - (BIN_W+1)'(1));

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      g_in     = g_ff;
      b_in     = b_ff;
      cmd      = '0;
      cmd.scan_idx = idx_ff[IDX_W-1:0];
      cmd.out_grp  = g_ff;
      cmd.out_bin  = b_ff;
      cmd.out_last = g_end && b_end;
      unique case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               priority if (req_mode == MODE_LOAD) begin
                  cmd.load = (stat.count < CNT_W'(MAX_POINTS)) &&
                             ({1'b0, req_group_label} < ng);
               end else if (req_mode == MODE_CLEAR) begin
                  cmd.clear = 1'b1;
               end else if (req_mode == MODE_QUERY) begin
                  if ({1'b0, req_query_index} >= stat.count) begin
                     state_in = ST_ERR;
                  end else begin
                     cmd.fetch_q   = 1'b1;
                     cmd.tally_clr = 1'b1;
                     state_in      = ST_QRD;
                  end
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_QRD: begin
            cmd.latch_q = 1'b1;
            idx_in      = '0;
            state_in    = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan_rd = 1'b1;
            idx_in      = idx_ff + CNT_W'(1);
            if (idx_in == stat.count) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            // wait for the last point to reach the tally
            if (!stat.pipe_busy) begin
               g_in     = '0;
               b_in     = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               cmd.out_load = 1'b1;
               if (b_end) begin
                  b_in = '0;
                  g_in = g_ff + GRP_W'(1);
                  if (g_end) state_in = ST_IDLE;
               end else begin
                  b_in = b_ff + BIN_W'(1);
               end
            end
         end
         ST_ERR: begin
            if (slot_free) begin
               cmd.out_load = 1'b1;
               cmd.out_err  = 1'b1;
               cmd.out_grp  = '0;
               cmd.out_bin  = '0;
               cmd.out_last = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      idx_ff <= idx_in;
      g_ff   <= g_in;
      b_ff   <= b_in;
   end

`ifndef SYNTHESIS
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> idx_ff < stat.count) else $error("scan past count");
   a_emit_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && cmd.out_load && cmd.out_last) |=> state_ff == ST_IDLE)
      else $error("emit did not finish");
   a_err_once: assert property (@(posedge clock) disable iff (reset)
      cmd.out_err |-> cmd.out_last) else $error("error result without last");
`endif
endmodule
